@@ src/tpa_pkg.sv @@
// Package for the triangle primitive assembler.
// Holds the transfer payload types and the operation and mode codes.
// No dependencies.
`timescale 1ns / 1ps

package tpa_pkg;

	localparam int FIELD_BITS = 32;

	typedef logic [FIELD_BITS-1:0] coord_field_t;

	localparam logic OP_BEGIN  = 1'b0;
	localparam logic OP_VERTEX = 1'b1;

	typedef logic [1:0] prim_mode_t;

	localparam prim_mode_t MODE_TRIANGLES = 2'd0;
	localparam prim_mode_t MODE_STRIP     = 2'd1;
	localparam prim_mode_t MODE_FAN       = 2'd2;

	typedef struct packed {
		logic         operation;
		prim_mode_t   prim_mode;
		coord_field_t x_coord;
		coord_field_t y_coord;
		coord_field_t z_coord;
	} vertex_item_t;

	typedef struct packed {
		coord_field_t corner0_x;
		coord_field_t corner0_y;
		coord_field_t corner0_z;
		coord_field_t corner1_x;
		coord_field_t corner1_y;
		coord_field_t corner1_z;
		coord_field_t corner2_x;
		coord_field_t corner2_y;
		coord_field_t corner2_z;
	} triangle_item_t;

endpackage

@@ src/triangle_primitive_assembler_top.sv @@
// Triangle primitive assembler, top level.
// Depends on tpa_pkg for the payload types and codes.
//
// Usage:
//   Vertex channel (vertex_valid / vertex_stall / vertex_item) carries begin
//   items (operation = begin, prim_mode selects triangles, strip or fan) and
//   vertex items (operation = vertex, x/y/z coordinate bits).
//   Triangle channel (triangle_valid / triangle_stall / triangle_item) carries
//   one assembled triangle, three corners of x/y/z bits.
//   Path: a vertex item passes the input register, then the result register,
//   before triangle_valid rises; a triangle stall can hold it in the input
//   register.
//   Throughput: one item per cycle while vertex_stall is low; the result
//   register lets a new item in while a finished triangle still waits.
//   Reset: mode returns to separate triangles with no vertices held; no
//   triangle is pending.
//   When the receiver stalls, the triangle holds, the input register holds an
//   item that would emit, and vertex_stall rises; items that emit nothing
//   still drain.
`timescale 1ns / 1ps

module triangle_primitive_assembler_top #(
	parameter int COORD_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   vertex_valid,
	output logic                   vertex_stall,
	input  tpa_pkg::vertex_item_t  vertex_item,
	output logic                   triangle_valid,
	input  logic                   triangle_stall,
	output tpa_pkg::triangle_item_t triangle_item
);
	import tpa_pkg::*;

	localparam int HOLD_BITS = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;

	typedef logic [HOLD_BITS-1:0] hold_t;

	// input register
	logic         valid_s1;
	vertex_item_t item_s1;

	// assembly state
	prim_mode_t mode_q;
	logic [1:0] pos_q;
	logic       parity_q;
	hold_t      a_x_q, a_y_q, a_z_q;
	hold_t      b_x_q, b_y_q, b_z_q;

	// result register
	logic           out_valid_q;
	triangle_item_t out_q;

	hold_t v_x, v_y, v_z;
	logic  is_vertex, mode_ok, emits, out_free, fire_s1, take_in;

	assign v_x = item_s1.x_coord[HOLD_BITS-1:0];
	assign v_y = item_s1.y_coord[HOLD_BITS-1:0];
	assign v_z = item_s1.z_coord[HOLD_BITS-1:0];

	assign is_vertex = (item_s1.operation == OP_VERTEX);
	assign mode_ok   = (mode_q == MODE_TRIANGLES) || (mode_q == MODE_STRIP) ||
		(mode_q == MODE_FAN);
	assign emits     = valid_s1 && is_vertex && mode_ok && (pos_q == 2'd2);
	assign out_free  = !out_valid_q || !triangle_stall;
	assign fire_s1   = valid_s1 && (!emits || out_free);
	assign vertex_stall = valid_s1 && !fire_s1;
	assign take_in   = vertex_valid && !vertex_stall;

	assign triangle_valid = out_valid_q;
	assign triangle_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= vertex_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_TRIANGLES;
			pos_q    <= 2'd0;
			parity_q <= 1'b0;
		end else if (fire_s1) begin
			if (!is_vertex) begin
				mode_q   <= item_s1.prim_mode;
				pos_q    <= 2'd0;
				parity_q <= 1'b0;
			end else if (mode_ok) begin
				if (pos_q != 2'd2) begin
					pos_q <= pos_q + 2'd1;
				end else begin
					case (mode_q)
						MODE_TRIANGLES: pos_q <= 2'd0;
						MODE_STRIP:     parity_q <= !parity_q;
						default:        ;
					endcase
				end
			end
		end
	end

	// held vertices, slot A and slot B
	always_ff @(posedge clk) begin
		if (fire_s1 && is_vertex && mode_ok) begin
			if (pos_q == 2'd0) begin
				a_x_q <= v_x;
				a_y_q <= v_y;
				a_z_q <= v_z;
			end else if (pos_q == 2'd1) begin
				b_x_q <= v_x;
				b_y_q <= v_y;
				b_z_q <= v_z;
			end else begin
				case (mode_q)
					MODE_STRIP: begin
						a_x_q <= b_x_q;
						a_y_q <= b_y_q;
						a_z_q <= b_z_q;
						b_x_q <= v_x;
						b_y_q <= v_y;
						b_z_q <= v_z;
					end
					MODE_FAN: begin
						b_x_q <= v_x;
						b_y_q <= v_y;
						b_z_q <= v_z;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && emits) begin
			out_valid_q <= 1'b1;
		end else if (!triangle_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// strip odd triangles swap the first two corners
	always_ff @(posedge clk) begin
		if (fire_s1 && emits) begin
			if ((mode_q == MODE_STRIP) && parity_q) begin
				out_q.corner0_x <= FIELD_BITS'(b_x_q);
				out_q.corner0_y <= FIELD_BITS'(b_y_q);
				out_q.corner0_z <= FIELD_BITS'(b_z_q);
				out_q.corner1_x <= FIELD_BITS'(a_x_q);
				out_q.corner1_y <= FIELD_BITS'(a_y_q);
				out_q.corner1_z <= FIELD_BITS'(a_z_q);
			end else begin
				out_q.corner0_x <= FIELD_BITS'(a_x_q);
				out_q.corner0_y <= FIELD_BITS'(a_y_q);
				out_q.corner0_z <= FIELD_BITS'(a_z_q);
				out_q.corner1_x <= FIELD_BITS'(b_x_q);
				out_q.corner1_y <= FIELD_BITS'(b_y_q);
				out_q.corner1_z <= FIELD_BITS'(b_z_q);
			end
			out_q.corner2_x <= FIELD_BITS'(v_x);
			out_q.corner2_y <= FIELD_BITS'(v_y);
			out_q.corner2_z <= FIELD_BITS'(v_z);
		end
	end

endmodule
